[rtl/plc_pkg.sv]
`timescale 1ns / 1ps

package plc_pkg;

  // Colour map selector codes; anything above MAP_BLUERED gives black
  typedef enum logic [3:0] {
    MAP_VIRIDIS = 4'd0,
    MAP_INFERNO = 4'd1,
    MAP_PLASMA  = 4'd2,
    MAP_MAGMA   = 4'd3,
    MAP_JET     = 4'd4,
    MAP_HOT     = 4'd5,
    MAP_COOL    = 4'd6,
    MAP_GRAY    = 4'd7,
    MAP_BLUERED = 4'd8
  } map_e;

  localparam logic [3:0] NUM_MAPS = 4'd9;
  localparam int         MAX_SEG  = 5;

  // Segment start points, resolved to fixed point where the precision is known
  typedef enum logic [3:0] {
    BP_ZERO,
    BP_EIGHTH1,
    BP_EIGHTH2,
    BP_EIGHTH3,
    BP_EIGHTH4,
    BP_EIGHTH5,
    BP_EIGHTH6,
    BP_EIGHTH7,
    BP_PCT33,
    BP_PCT66
  } bp_code_e;

  // Segment slope reciprocals
  typedef enum logic [2:0] {
    RC_ONE,
    RC_FOUR,
    RC_EIGHT,
    RC_33,
    RC_34
  } rc_e;

  // One segment: anchors held doubled, channel 0 red, 1 green, 2 blue
  typedef struct packed {
    bp_code_e        bp;
    rc_e             rc;
    logic [2:0][8:0] c0;
    logic [2:0][8:0] c1;
  } seg_t;

  // Segment data handed from the front end to the interpolator
  typedef struct packed {
    rc_e             rc;
    logic [2:0][8:0] c0;
    logic [2:0][9:0] delta;
    logic            black;
  } seg_info_t;

  function automatic seg_t mk_seg(input bp_code_e bp, input rc_e rc,
                                  input int r0, input int g0, input int b0,
                                  input int r1, input int g1, input int b1);
    seg_t s;
    s.bp    = bp;
    s.rc    = rc;
    s.c0[0] = 9'(r0);
    s.c0[1] = 9'(g0);
    s.c0[2] = 9'(b0);
    s.c1[0] = 9'(r1);
    s.c1[1] = 9'(g1);
    s.c1[2] = 9'(b1);
    return s;
  endfunction

  // Number of segments in each map
  function automatic logic [2:0] map_nseg(input logic [3:0] sel);
    logic [2:0] n;
    case (sel)
      MAP_VIRIDIS: n = 3'd4;
      MAP_INFERNO: n = 3'd3;
      MAP_PLASMA:  n = 3'd3;
      MAP_MAGMA:   n = 3'd3;
      MAP_JET:     n = 3'd5;
      MAP_HOT:     n = 3'd3;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  // Segment table of all maps
  function automatic seg_t seg_def(input logic [3:0] sel, input logic [2:0] k);
    seg_t s;
    s = mk_seg(BP_ZERO, RC_ONE, 0, 0, 0, 0, 0, 0);
    case (sel)
      MAP_VIRIDIS: begin
        case (k)
          3'd0:    s = mk_seg(BP_ZERO,    RC_FOUR, 136,   2, 168, 118, 164, 278);
          3'd1:    s = mk_seg(BP_EIGHTH2, RC_FOUR, 118, 164, 278,  66, 290, 280);
          3'd2:    s = mk_seg(BP_EIGHTH4, RC_FOUR,  66, 290, 280, 188, 402, 196);
          3'd3:    s = mk_seg(BP_EIGHTH6, RC_FOUR, 188, 402, 196, 506, 462,  74);
          default: s = mk_seg(BP_ZERO,    RC_ONE,    0,   0,   0,   0,   0,   0);
        endcase
      end
      MAP_INFERNO: begin
        case (k)
          3'd0:    s = mk_seg(BP_ZERO,  RC_33,   0,   0,   0, 174,  32, 220);
          3'd1:    s = mk_seg(BP_PCT33, RC_33, 174,  32, 220, 376, 110, 168);
          3'd2:    s = mk_seg(BP_PCT66, RC_34, 376, 110, 168, 504, 472, 148);
          default: s = mk_seg(BP_ZERO,  RC_ONE,  0,   0,   0,   0,   0,   0);
        endcase
      end
      MAP_PLASMA: begin
        case (k)
          3'd0:    s = mk_seg(BP_ZERO,  RC_33,  26,  16, 270, 252,   6, 278);
          3'd1:    s = mk_seg(BP_PCT33, RC_33, 252,   6, 278, 408, 142, 228);
          3'd2:    s = mk_seg(BP_PCT66, RC_34, 408, 142, 228, 480, 430, 100);
          default: s = mk_seg(BP_ZERO,  RC_ONE,  0,   0,   0,   0,   0,   0);
        endcase
      end
      MAP_MAGMA: begin
        case (k)
          3'd0:    s = mk_seg(BP_ZERO,  RC_33,   0,   0,   0, 160,  36, 240);
          3'd1:    s = mk_seg(BP_PCT33, RC_33, 160,  36, 240, 360, 100, 180);
          3'd2:    s = mk_seg(BP_PCT66, RC_34, 360, 100, 180, 504, 440, 360);
          default: s = mk_seg(BP_ZERO,  RC_ONE,  0,   0,   0,   0,   0,   0);
        endcase
      end
      MAP_JET: begin
        case (k)
          3'd0:    s = mk_seg(BP_ZERO,    RC_EIGHT,   0,   0, 256,   0,   0, 510);
          3'd1:    s = mk_seg(BP_EIGHTH1, RC_FOUR,    0,   0, 510,   0, 510, 510);
          3'd2:    s = mk_seg(BP_EIGHTH3, RC_FOUR,    0, 510, 510, 510, 510,   0);
          3'd3:    s = mk_seg(BP_EIGHTH5, RC_FOUR,  510, 510,   0, 510,   0,   0);
          3'd4:    s = mk_seg(BP_EIGHTH7, RC_EIGHT, 510,   0,   0, 255,   0,   0);
          default: s = mk_seg(BP_ZERO,    RC_ONE,     0,   0,   0,   0,   0,   0);
        endcase
      end
      MAP_HOT: begin
        case (k)
          3'd0:    s = mk_seg(BP_ZERO,  RC_33,   0,   0,   0, 510,   0,   0);
          3'd1:    s = mk_seg(BP_PCT33, RC_33, 510,   0,   0, 510, 510,   0);
          3'd2:    s = mk_seg(BP_PCT66, RC_34, 510, 510,   0, 510, 510, 510);
          default: s = mk_seg(BP_ZERO,  RC_ONE,  0,   0,   0,   0,   0,   0);
        endcase
      end
      MAP_COOL:    s = mk_seg(BP_ZERO, RC_ONE,   0, 510, 510, 510,   0, 510);
      MAP_GRAY:    s = mk_seg(BP_ZERO, RC_ONE,   0,   0,   0, 510, 510, 510);
      MAP_BLUERED: s = mk_seg(BP_ZERO, RC_ONE,   0,   0, 510, 510,   0,   0);
      default:     s = mk_seg(BP_ZERO, RC_ONE,   0,   0,   0,   0,   0,   0);
    endcase
    return s;
  endfunction

endpackage

[rtl/piecewise_linear_colormap_core.sv]
`timescale 1ns / 1ps
// Scalar to RGB colour map, piecewise linear.
// Input channel: in_valid_i / in_stall_o carry one signed Q16 sample per
// transaction on sample_value_i; it is clamped to 0..1.0 before mapping.
// Output channel: out_valid_o / out_stall_i carry one pixel per transaction
// on red_o, green_o and blue_o.
// Configuration: map_select_i is written whenever map_select_we_i is high;
// write it only while no transaction is in flight. Codes above 8 give black.
// From input transaction to output valid a sample passes clamp, segment
// choice, position multiply, slope multiply and saturation. One sample is
// taken every cycle while no stall holds the pipeline; the rate is set by the
// five-register pipeline, with at most one multiply per channel in each stage.
// Reset clears all valid bits and sets the map to viridis.
// When the receiver stalls, the pipeline fills up behind the output register
// and in_stall_o rises only once every stage holds a pixel; nothing is lost
// or repeated.
module piecewise_linear_colormap_core import plc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               map_select_we_i,
  input  logic [3:0]         map_select_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [17:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  logic [3:0]         map_sel_r_q;
  logic               front_ready;
  logic               mid_valid;
  logic               mid_ready;
  logic [FRAC_BITS:0] mid_diff;
  seg_info_t          mid_info;

  // Map selection register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sel_r_q <= MAP_VIRIDIS;
    end else if (map_select_we_i) begin
      map_sel_r_q <= map_select_i;
    end
  end

  plc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (front_ready),
    .sample_value_i(sample_value_i),
    .map_sel_i     (map_sel_r_q),
    .out_valid_o   (mid_valid),
    .out_ready_i   (mid_ready),
    .diff_o        (mid_diff),
    .info_o        (mid_info)
  );

  plc_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mid_valid),
    .in_ready_o (mid_ready),
    .diff_i     (mid_diff),
    .info_i     (mid_info),
    .out_valid_o(out_valid_o),
    .out_ready_i(!out_stall_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

  assign in_stall_o = !front_ready;

  // Input only backs up when the output is full and held
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // With no backpressure an accepted sample reaches the output without being held
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_valid_i && !in_stall_o, 5) && $past(!out_stall_i, 4) &&
     $past(!out_stall_i, 3) && $past(!out_stall_i, 2) && $past(!out_stall_i, 1) &&
     $past(rst_ni, 4) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1))
    |-> out_valid_o)
    else $error("pixel did not arrive after five unstalled cycles");

  // Selector changes only through the write port
  a_sel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!map_select_we_i && (in_valid_i || out_valid_o)) |=> $stable(map_sel_r_q))
    else $error("map selection changed without a write");

endmodule

[rtl/plc_front.sv]
`timescale 1ns / 1ps

module plc_front import plc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [17:0]      sample_value_i,
  input  logic [3:0]              map_sel_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [FRAC_BITS:0]      diff_o,
  output seg_info_t               info_o
);

  localparam int     VW   = FRAC_BITS + 1;
  localparam int     UPSH = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  localparam int     DNSH = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);
  localparam int     SW   = 17 + UPSH;
  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint BP33 = (33 * ONE + 50) / 100;
  localparam longint BP66 = (66 * ONE + 50) / 100;

  // Breakpoint code to fixed-point value
  function automatic logic [VW-1:0] bp_val(input bp_code_e c);
    logic [VW-1:0] r;
    case (c)
      BP_ZERO:    r = '0;
      BP_EIGHTH1: r = VW'(ONE / 8);
      BP_EIGHTH2: r = VW'(2 * ONE / 8);
      BP_EIGHTH3: r = VW'(3 * ONE / 8);
      BP_EIGHTH4: r = VW'(4 * ONE / 8);
      BP_EIGHTH5: r = VW'(5 * ONE / 8);
      BP_EIGHTH6: r = VW'(6 * ONE / 8);
      BP_EIGHTH7: r = VW'(7 * ONE / 8);
      BP_PCT33:   r = VW'(BP33);
      BP_PCT66:   r = VW'(BP66);
      default:    r = '0;
    endcase
    return r;
  endfunction

  logic            s1_valid_q;
  logic [VW-1:0]   s1_v_q, s1_v_d;
  logic [3:0]      s1_sel_q;
  logic            s2_valid_q;
  logic [VW-1:0]   s2_diff_q, s2_diff_d;
  seg_info_t       s2_info_q, s2_info_d;
  logic            s1_ready, s2_ready;
  logic [16:0]     clamped;
  logic [SW-1:0]   scaled;

  // Backpressure chain
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage 1: clamp to the unit range and rescale to the working precision
  always_comb begin
    if (sample_value_i[17]) begin
      clamped = '0;
    end else if (sample_value_i > 18'sd65536) begin
      clamped = 17'd65536;
    end else begin
      clamped = sample_value_i[16:0];
    end
    scaled = (SW'(clamped) << UPSH) >> DNSH;
    s1_v_d = scaled[VW-1:0];
  end

  // Stage 2: pick the last segment whose start is not above the sample
  always_comb begin
    logic [2:0] nseg;
    logic [2:0] k;
    seg_t       cand;
    seg_t       seg_k;
    nseg = map_nseg(s1_sel_q);
    k    = '0;
    for (int i = 1; i < MAX_SEG; i++) begin
      cand = seg_def(s1_sel_q, 3'(i));
      if ((3'(i) < nseg) && (s1_v_q >= bp_val(cand.bp))) begin
        k = 3'(i);
      end
    end
    seg_k           = seg_def(s1_sel_q, k);
    s2_diff_d       = s1_v_q - bp_val(seg_k.bp);
    s2_info_d.rc    = seg_k.rc;
    s2_info_d.c0    = seg_k.c0;
    for (int c = 0; c < 3; c++) begin
      s2_info_d.delta[c] = {1'b0, seg_k.c1[c]} - {1'b0, seg_k.c0[c]};
    end
    s2_info_d.black = (s1_sel_q >= NUM_MAPS);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_v_q   <= s1_v_d;
      s1_sel_q <= map_sel_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_diff_q <= s2_diff_d;
      s2_info_q <= s2_info_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign diff_o      = s2_diff_q;
  assign info_o      = s2_info_q;

endmodule

[rtl/plc_interp.sv]
`timescale 1ns / 1ps

module plc_interp import plc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FRAC_BITS:0] diff_i,
  input  seg_info_t          info_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  localparam int     VW  = FRAC_BITS + 1;
  localparam int     RW  = FRAC_BITS + 4;
  localparam int     TW  = FRAC_BITS + 2;
  localparam int     PW  = TW + 11;
  localparam int     AW  = FRAC_BITS + 14;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint R33 = (100 * ONE + 16) / 33;
  localparam longint R34 = (100 * ONE + 17) / 34;

  function automatic logic [RW-1:0] rcp_val(input rc_e c);
    logic [RW-1:0] r;
    case (c)
      RC_ONE:   r = RW'(ONE);
      RC_FOUR:  r = RW'(4 * ONE);
      RC_EIGHT: r = RW'(8 * ONE);
      RC_33:    r = RW'(R33);
      RC_34:    r = RW'(R34);
      default:  r = RW'(ONE);
    endcase
    return r;
  endfunction

  logic                 s3_valid_q, s4_valid_q, out_valid_q;
  logic                 s3_ready, s4_ready, out_ready;
  logic [VW+RW-1:0]     prod;
  logic [TW-1:0]        s3_t_q;
  seg_info_t            s3_info_q;
  logic signed [PW-1:0] s4_p_q [3];
  logic signed [PW-1:0] s4_p_d [3];
  logic [2:0][8:0]      s4_c0_q;
  logic                 s4_black_q;
  logic [2:0][7:0]      chan_d;
  logic [2:0][7:0]      chan_q;

  // Backpressure chain
  assign out_ready  = !out_valid_q || out_ready_i;
  assign s4_ready   = !s4_valid_q || out_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign in_ready_o = s3_ready;

  // Stage 3: position within the segment
  assign prod = diff_i * rcp_val(info_i.rc);

  // Stage 4: slope times position, per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s4_p_d[c] = $signed({1'b0, s3_t_q}) * $signed(s3_info_q.delta[c]);
    end
  end

  // Stage 5: add anchor, saturate to 0..255; a black selection forces zero
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] shifted;
    for (int c = 0; c < 3; c++) begin
      acc     = $signed({{(AW - FRAC_BITS - 9){1'b0}}, s4_c0_q[c], {FRAC_BITS{1'b0}}})
                + AW'(s4_p_q[c]);
      shifted = acc >>> (FRAC_BITS + 1);
      if (s4_black_q || (acc <= 0)) begin
        chan_d[c] = 8'd0;
      end else if (shifted[AW-1:8] != '0) begin
        chan_d[c] = 8'hFF;
      end else begin
        chan_d[c] = shifted[7:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= in_valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      s3_t_q    <= prod[FRAC_BITS +: TW];
      s3_info_q <= info_i;
    end
    if (s4_ready && s3_valid_q) begin
      s4_p_q     <= s4_p_d;
      s4_c0_q    <= s3_info_q.c0;
      s4_black_q <= s3_info_q.black;
    end
    if (out_ready && s4_valid_q) begin
      chan_q <= chan_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = chan_q[0];
  assign green_o     = chan_q[1];
  assign blue_o      = chan_q[2];

endmodule
